[rtl/gpco_pkg.sv]
package gpco_pkg;

  localparam int unsigned MaxSegmentsDefault = 64;
  localparam int unsigned CoordBitsDefault   = 32;
  localparam int unsigned PointBits          = 32;
  localparam int unsigned DistBits           = 2 * PointBits + 1;
  localparam int unsigned RoleBits           = 4;
  localparam int unsigned IndexBits          = 6;
  localparam int unsigned ResultCap          = 64;
  localparam int unsigned ResultCountBits    = 7;
  localparam int unsigned CfgIndexBits       = 3;
  localparam int unsigned CfgDataBits        = 32;

  typedef enum logic [CfgIndexBits-1:0] {
    REG_START_X          = 3'd0,
    REG_START_Y          = 3'd1,
    REG_START_FROM_FIRST = 3'd2,
    REG_FORBID_REVERSE   = 3'd3,
    REG_ROLE_FILTER      = 3'd4,
    REG_KEEP_ORDER       = 3'd5
  } reg_index_t;

endpackage

[rtl/gpco_seg_if.sv]
interface gpco_seg_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [gpco_pkg::PointBits-1:0]    first_x;
  logic signed [gpco_pkg::PointBits-1:0]    first_y;
  logic signed [gpco_pkg::PointBits-1:0]    end_x;
  logic signed [gpco_pkg::PointBits-1:0]    end_y;
  logic                                     reversible;
  logic        [gpco_pkg::RoleBits-1:0]     seg_role;
  logic                                     final_item;

  modport source (output valid, first_x, first_y, end_x, end_y, reversible, seg_role,
                  final_item, input ready);
  modport sink (input valid, first_x, first_y, end_x, end_y, reversible, seg_role,
                final_item, output ready);
endinterface

[rtl/gpco_chain_if.sv]
interface gpco_chain_if;
  logic                               valid;
  logic                               ready;
  logic [gpco_pkg::IndexBits-1:0]     orig_index;
  logic                               was_reversed;
  logic                               run_end;

  modport source (output valid, orig_index, was_reversed, run_end, input ready);
  modport sink (input valid, orig_index, was_reversed, run_end, output ready);
endinterface

[rtl/gpco_ram.sv]
module gpco_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/gpco_dist.sv]
module gpco_dist (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [gpco_pkg::PointBits-1:0] ax,
  input  logic signed [gpco_pkg::PointBits-1:0] ay,
  input  logic signed [gpco_pkg::PointBits-1:0] bx,
  input  logic signed [gpco_pkg::PointBits-1:0] by,
  output logic                                  done,
  output logic [gpco_pkg::DistBits-1:0]         sq_dist
);

  localparam int unsigned PW = gpco_pkg::PointBits;

  typedef enum logic [1:0] {D_IDLE, D_SQX, D_SQY, D_SUM} dstate_t;

  dstate_t         state;
  logic [PW-1:0]   dx;
  logic [PW-1:0]   dy;
  logic [2*PW-1:0] sqx;
  logic [2*PW-1:0] sqy;
  logic [PW:0]     diff_x;
  logic [PW:0]     diff_y;
  logic [PW:0]     abs_x;
  logic [PW:0]     abs_y;
  logic [PW-1:0]   mul_op;
  logic [2*PW-1:0] prod;

  assign diff_x = {ax[PW-1], ax} - {bx[PW-1], bx};
  assign diff_y = {ay[PW-1], ay} - {by[PW-1], by};
  assign abs_x  = diff_x[PW] ? -diff_x : diff_x;
  assign abs_y  = diff_y[PW] ? -diff_y : diff_y;
  assign mul_op = (state == D_SQX) ? dx : dy;
  assign prod   = (2*PW)'(mul_op) * (2*PW)'(mul_op);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            dx    <= abs_x[PW-1:0];
            dy    <= abs_y[PW-1:0];
            state <= D_SQX;
          end
        end
        D_SQX: begin
          sqx   <= prod;
          state <= D_SQY;
        end
        D_SQY: begin
          sqy   <= prod;
          state <= D_SUM;
        end
        D_SUM: begin
          sq_dist <= {1'b0, sqx} + {1'b0, sqy};
          done    <= 1'b1;
          state   <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

[rtl/greedy_path_chain_order.sv]
// Orders a set of path segments by greedy nearest neighbor. Segments load one per cycle
// while segs.ready is high; the item flagged final_item closes the set and segs.ready
// stays low until the last result of that set has been generated, or until the role
// filter is found to leave no segment. Keep-order mode emits one result per cycle while
// the output is not stalled. Otherwise a sweep over the stored segments applies the role
// filter, and each result then scans every stored segment: it skips one that is already
// used or filtered out, measures the distance to the first point of every other one, and
// also to the end point of a reversible one when reversal is not forbidden. The distance
// unit has a single 32x32 multiplier, which forms both squared differences of every
// candidate endpoint in turn. Segments beyond MAX_SEGMENTS are dropped, at most 64
// results are produced per set, and the last one carries run_end.
module greedy_path_chain_order #(
  parameter int unsigned MAX_SEGMENTS = gpco_pkg::MaxSegmentsDefault,
  parameter int unsigned COORD_BITS   = gpco_pkg::CoordBitsDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  gpco_seg_if.sink                          segs,
  gpco_chain_if.source                      chain,
  input  logic                              wr_en,
  input  logic [gpco_pkg::CfgIndexBits-1:0] wr_index,
  input  logic [gpco_pkg::CfgDataBits-1:0]  wr_data
);

  localparam int unsigned AW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned RB = gpco_pkg::RoleBits;
  localparam int unsigned SW = 4 * C + RB + 1;
  localparam int unsigned PW = gpco_pkg::PointBits;
  localparam int unsigned NW = gpco_pkg::ResultCountBits;
  localparam int unsigned IW = gpco_pkg::IndexBits;

  typedef enum logic [3:0] {
    S_IDLE, S_KEEP, S_INIT_RD, S_INIT_WR, S_SC_RD, S_SC_LAT, S_SC_D1, S_SC_D2, S_PICK
  } state_t;

  state_t                     state;
  logic signed [PW-1:0]       start_x;
  logic signed [PW-1:0]       start_y;
  logic                       start_from_first;
  logic                       forbid_reverse;
  logic [RB-1:0]              role_filter;
  logic                       keep_order;

  logic [CW-1:0]              count;
  logic [CW-1:0]              idx;
  logic [CW-1:0]              left;
  logic [CW-1:0]              best;
  logic [NW-1:0]              n_out;
  logic                       found;
  logic                       best_rev;
  logic [gpco_pkg::DistBits-1:0] best_d;
  logic signed [PW-1:0]       front_x;
  logic signed [PW-1:0]       front_y;
  logic signed [PW-1:0]       cur_x;
  logic signed [PW-1:0]       cur_y;
  logic signed [PW-1:0]       best_x;
  logic signed [PW-1:0]       best_y;
  logic signed [PW-1:0]       ent_x;
  logic signed [PW-1:0]       ent_y;
  logic signed [PW-1:0]       ext_x;
  logic signed [PW-1:0]       ext_y;
  logic                       can_rev;

  logic                       out_valid;
  logic [IW-1:0]              out_index;
  logic                       out_rev;
  logic                       out_end;

  logic                       accept;
  logic                       room;
  logic [CW-1:0]              count_next;
  logic [CW-1:0]              idx_inc;
  logic                       can_emit;
  logic signed [PW-1:0]       new_x;
  logic signed [PW-1:0]       new_y;
  logic signed [PW-1:0]       front_x_next;
  logic signed [PW-1:0]       front_y_next;

  logic                       st_we;
  logic [SW-1:0]              st_wdata;
  logic [SW-1:0]              st_rdata;
  logic                       rem_we;
  logic [AW-1:0]              rem_waddr;
  logic                       rem_wdata;
  logic                       rem_rdata;

  logic signed [C-1:0]        rd_en_x;
  logic signed [C-1:0]        rd_en_y;
  logic signed [C-1:0]        rd_ex_x;
  logic signed [C-1:0]        rd_ex_y;
  logic [RB-1:0]              rd_role;
  logic                       rd_rev;
  logic                       role_match;
  logic [CW-1:0]              left_inc;

  logic                       dist_start;
  logic signed [PW-1:0]       dist_bx;
  logic signed [PW-1:0]       dist_by;
  logic                       dist_done;
  logic [gpco_pkg::DistBits-1:0] cand_dist;
  logic                       pick_last;
  logic                       keep_last;

  logic [CW+IW-1:0]           idx_wide;
  logic [CW+IW-1:0]           best_wide;

  assign accept     = segs.valid && segs.ready;
  assign segs.ready = (state == S_IDLE);
  assign room       = (count < CW'(MAX_SEGMENTS));
  assign count_next = room ? count + CW'(1) : count;
  assign idx_inc    = idx + CW'(1);
  assign can_emit   = !out_valid || chain.ready;

  assign new_x        = PW'(signed'(segs.first_x[C-1:0]));
  assign new_y        = PW'(signed'(segs.first_y[C-1:0]));
  assign front_x_next = (count == '0) ? new_x : front_x;
  assign front_y_next = (count == '0) ? new_y : front_y;

  assign st_we    = accept && room;
  assign st_wdata = {segs.seg_role, segs.reversible, segs.end_y[C-1:0], segs.end_x[C-1:0],
                     segs.first_y[C-1:0], segs.first_x[C-1:0]};

  assign rd_en_x    = st_rdata[C-1:0];
  assign rd_en_y    = st_rdata[2*C-1:C];
  assign rd_ex_x    = st_rdata[3*C-1:2*C];
  assign rd_ex_y    = st_rdata[4*C-1:3*C];
  assign rd_rev     = st_rdata[4*C];
  assign rd_role    = st_rdata[SW-1:4*C+1];
  assign role_match = (role_filter == '0) || (rd_role == role_filter);
  assign left_inc   = left + CW'(role_match);

  assign pick_last = (left == CW'(1)) || (n_out == NW'(gpco_pkg::ResultCap - 1));
  assign keep_last = (idx_inc == count) || (n_out == NW'(gpco_pkg::ResultCap - 1));

  assign rem_we    = (state == S_INIT_WR) || ((state == S_PICK) && can_emit);
  assign rem_waddr = (state == S_INIT_WR) ? idx[AW-1:0] : best[AW-1:0];
  assign rem_wdata = (state == S_INIT_WR) ? role_match : 1'b0;

  assign dist_start = ((state == S_SC_LAT) && rem_rdata) ||
                      ((state == S_SC_D1) && dist_done && can_rev);
  assign dist_bx    = (state == S_SC_LAT) ? PW'(rd_en_x) : ext_x;
  assign dist_by    = (state == S_SC_LAT) ? PW'(rd_en_y) : ext_y;

  assign idx_wide  = {{IW{1'b0}}, idx};
  assign best_wide = {{IW{1'b0}}, best};

  gpco_ram #(.WIDTH(SW), .DEPTH(MAX_SEGMENTS)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (count[AW-1:0]),
    .wdata (st_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (st_rdata)
  );

  gpco_ram #(.WIDTH(1), .DEPTH(MAX_SEGMENTS)) u_remain (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (rem_rdata)
  );

  gpco_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .start   (dist_start),
    .ax      (cur_x),
    .ay      (cur_y),
    .bx      (dist_bx),
    .by      (dist_by),
    .done    (dist_done),
    .sq_dist (cand_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x          <= '0;
      start_y          <= '0;
      start_from_first <= 1'b0;
      forbid_reverse   <= 1'b0;
      role_filter      <= '0;
      keep_order       <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        gpco_pkg::REG_START_X:          start_x          <= wr_data;
        gpco_pkg::REG_START_Y:          start_y          <= wr_data;
        gpco_pkg::REG_START_FROM_FIRST: start_from_first <= wr_data[0];
        gpco_pkg::REG_FORBID_REVERSE:   forbid_reverse   <= wr_data[0];
        gpco_pkg::REG_ROLE_FILTER:      role_filter      <= wr_data[RB-1:0];
        gpco_pkg::REG_KEEP_ORDER:       keep_order       <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      left      <= '0;
      n_out     <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
      front_x   <= '0;
      front_y   <= '0;
      cur_x     <= '0;
      cur_y     <= '0;
    end else begin
      if (chain.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            front_x <= front_x_next;
            front_y <= front_y_next;
            count   <= count_next;
            idx     <= '0;
            left    <= '0;
            n_out   <= '0;
            if (segs.final_item) begin
              cur_x <= start_from_first ? front_x_next : start_x;
              cur_y <= start_from_first ? front_y_next : start_y;
              if (count_next == '0) begin
                count <= '0;
              end else if (keep_order) begin
                state <= S_KEEP;
              end else begin
                state <= S_INIT_RD;
              end
            end
          end
        end
        S_KEEP: begin
          if (can_emit) begin
            out_valid <= 1'b1;
            out_index <= idx_wide[IW-1:0];
            out_rev   <= 1'b0;
            out_end   <= keep_last;
            n_out     <= n_out + NW'(1);
            idx       <= idx_inc;
            if (keep_last) begin
              count <= '0;
              state <= S_IDLE;
            end
          end
        end
        S_INIT_RD: begin
          state <= S_INIT_WR;
        end
        S_INIT_WR: begin
          left <= left_inc;
          if (idx_inc == count) begin
            idx   <= '0;
            found <= 1'b0;
            if (left_inc == '0) begin
              count <= '0;
              state <= S_IDLE;
            end else begin
              state <= S_SC_RD;
            end
          end else begin
            idx   <= idx_inc;
            state <= S_INIT_RD;
          end
        end
        S_SC_RD: begin
          state <= S_SC_LAT;
        end
        S_SC_LAT: begin
          ent_x   <= PW'(rd_en_x);
          ent_y   <= PW'(rd_en_y);
          ext_x   <= PW'(rd_ex_x);
          ext_y   <= PW'(rd_ex_y);
          can_rev <= rd_rev && !forbid_reverse;
          if (rem_rdata) begin
            state <= S_SC_D1;
          end else if (idx_inc == count) begin
            state <= S_PICK;
          end else begin
            idx   <= idx_inc;
            state <= S_SC_RD;
          end
        end
        S_SC_D1: begin
          if (dist_done) begin
            if (!found || (cand_dist < best_d)) begin
              found    <= 1'b1;
              best_d   <= cand_dist;
              best     <= idx;
              best_rev <= 1'b0;
              best_x   <= ext_x;
              best_y   <= ext_y;
            end
            if (can_rev) begin
              state <= S_SC_D2;
            end else if (idx_inc == count) begin
              state <= S_PICK;
            end else begin
              idx   <= idx_inc;
              state <= S_SC_RD;
            end
          end
        end
        S_SC_D2: begin
          if (dist_done) begin
            if (cand_dist < best_d) begin
              best_d   <= cand_dist;
              best     <= idx;
              best_rev <= 1'b1;
              best_x   <= ent_x;
              best_y   <= ent_y;
            end
            if (idx_inc == count) begin
              state <= S_PICK;
            end else begin
              idx   <= idx_inc;
              state <= S_SC_RD;
            end
          end
        end
        S_PICK: begin
          if (can_emit) begin
            out_valid <= 1'b1;
            out_index <= best_wide[IW-1:0];
            out_rev   <= best_rev;
            out_end   <= pick_last;
            n_out     <= n_out + NW'(1);
            left      <= left - CW'(1);
            cur_x     <= best_x;
            cur_y     <= best_y;
            idx       <= '0;
            found     <= 1'b0;
            if (pick_last) begin
              count <= '0;
              state <= S_IDLE;
            end else begin
              state <= S_SC_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign chain.valid        = out_valid;
  assign chain.orig_index   = out_index;
  assign chain.was_reversed = out_rev;
  assign chain.run_end      = out_end;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SEGMENTS))
    else $error("stored segment count exceeds capacity");

  a_left_bound: assert property (@(posedge clk) disable iff (rst)
    left <= count)
    else $error("remaining segment count exceeds stored count");

  a_dist_wait: assert property (@(posedge clk) disable iff (rst)
    dist_done |-> (state == S_SC_D1 || state == S_SC_D2))
    else $error("distance result arrived outside a scan wait");

endmodule

[test/gpco_chain_checker.sv]
module gpco_chain_checker (
  input  logic        clk,
  input  logic        rst,
  gpco_seg_if         segs,
  gpco_chain_if       chain,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  output int          errors,
  output int          pending,
  output int          chains_done,
  output int          steps_checked
);

  typedef struct packed {
    logic [gpco_pkg::IndexBits-1:0] idx;
    logic                           rev;
    logic                           last;
  } chain_step_t;

  chain_step_t steps_due[$];

  logic signed [31:0] fx [64];
  logic signed [31:0] fy [64];
  logic signed [31:0] ex [64];
  logic signed [31:0] ey [64];
  logic               can_flip [64];
  logic [3:0]         role [64];
  int                 stored;

  logic signed [31:0] org_x, org_y;
  logic               from_first, no_flip, hold_order;
  logic [3:0]         role_keep;

  assign pending = steps_due.size();

  function automatic logic [65:0] sqdist(logic signed [31:0] ax, logic signed [31:0] ay,
                                         logic signed [31:0] bx, logic signed [31:0] by);
    longint dx, dy;
    logic [65:0] ux, uy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    ux = 66'(dx);
    uy = 66'(dy);
    return ux * ux + uy * uy;
  endfunction

  task automatic plan_chain();
    logic        used [64];
    int          left, n, best;
    logic        brev, found;
    logic [65:0] bd, d;
    logic signed [31:0] cx, cy;
    chain_step_t s;
    left = 0;
    n = 0;
    if (hold_order) begin
      for (int i = 0; i < stored && n < gpco_pkg::ResultCap; i++) begin
        s.idx = gpco_pkg::IndexBits'(i);
        s.rev = 1'b0;
        s.last = (i + 1 == stored) || (n + 1 == gpco_pkg::ResultCap);
        steps_due = {steps_due, s};
        n++;
      end
      return;
    end
    for (int i = 0; i < 64; i++) begin
      used[i] = 1'b1;
      if (i < stored && (role_keep == 0 || role[i] == role_keep)) begin
        used[i] = 1'b0;
        left++;
      end
    end
    if (from_first) begin
      cx = fx[0];
      cy = fy[0];
    end else begin
      cx = org_x;
      cy = org_y;
    end
    while (left > 0 && n < gpco_pkg::ResultCap) begin
      found = 1'b0;
      best = 0;
      brev = 1'b0;
      bd = '0;
      for (int i = 0; i < stored; i++) begin
        if (used[i]) continue;
        d = sqdist(cx, cy, fx[i], fy[i]);
        if (!found || d < bd) begin
          found = 1'b1;
          bd = d;
          best = i;
          brev = 1'b0;
        end
        if (can_flip[i] && !no_flip) begin
          d = sqdist(cx, cy, ex[i], ey[i]);
          if (d < bd) begin
            bd = d;
            best = i;
            brev = 1'b1;
          end
        end
      end
      used[best] = 1'b1;
      left--;
      cx = brev ? fx[best] : ex[best];
      cy = brev ? fy[best] : ey[best];
      s.idx = gpco_pkg::IndexBits'(best);
      s.rev = brev;
      s.last = (left == 0) || (n + 1 == gpco_pkg::ResultCap);
      steps_due = {steps_due, s};
      n++;
    end
  endtask

  always @(posedge clk) begin
    chain_step_t want;
    if (rst) begin
      stored = 0;
      org_x <= '0;
      org_y <= '0;
      from_first <= 1'b0;
      no_flip <= 1'b0;
      hold_order <= 1'b0;
      role_keep <= '0;
      errors <= 0;
      chains_done <= 0;
      steps_checked <= 0;
      steps_due.delete();
    end else begin
      if (wr_en) begin
        case (gpco_pkg::reg_index_t'(wr_index))
          gpco_pkg::REG_START_X:          org_x <= wr_data;
          gpco_pkg::REG_START_Y:          org_y <= wr_data;
          gpco_pkg::REG_START_FROM_FIRST: from_first <= wr_data[0];
          gpco_pkg::REG_FORBID_REVERSE:   no_flip <= wr_data[0];
          gpco_pkg::REG_ROLE_FILTER:      role_keep <= wr_data[3:0];
          gpco_pkg::REG_KEEP_ORDER:       hold_order <= wr_data[0];
          default: ;
        endcase
      end
      if (segs.valid && segs.ready) begin
        if (stored < 64) begin
          fx[stored] = segs.first_x;
          fy[stored] = segs.first_y;
          ex[stored] = segs.end_x;
          ey[stored] = segs.end_y;
          can_flip[stored] = segs.reversible;
          role[stored] = segs.seg_role;
          stored = stored + 1;
        end
        if (segs.final_item) begin
          plan_chain();
          stored = 0;
          chains_done <= chains_done + 1;
        end
      end
      if (chain.valid && chain.ready) begin
        steps_checked <= steps_checked + 1;
        if (steps_due.size() == 0) begin
          $display("%0t: unexpected result idx=%0d rev=%0b end=%0b", $time,
                   chain.orig_index, chain.was_reversed, chain.run_end);
          errors <= errors + 1;
        end else begin
          want = steps_due.pop_front();
          if (want.idx !== chain.orig_index || want.rev !== chain.was_reversed ||
              want.last !== chain.run_end) begin
            $display("%0t: expected idx=%0d rev=%0b end=%0b, got idx=%0d rev=%0b end=%0b",
                     $time, want.idx, want.rev, want.last, chain.orig_index,
                     chain.was_reversed, chain.run_end);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

[test/tb.sv]
module tb;

  typedef struct {
    logic signed [31:0] fx, fy, ex, ey;
    logic               rev;
    logic [3:0]         role;
  } seg_t;

  localparam logic signed [31:0] CMIN = 32'sh8000_0000;
  localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic [2:0]  wr_index = '0;
  logic [31:0] wr_data = '0;
  logic        steady = 1'b0;
  int          errors, pending, chains_done, steps_checked;
  int          items_sent = 0;
  int          big_sets = 0;

  gpco_seg_if   segs ();
  gpco_chain_if chain ();

  greedy_path_chain_order DUT (
    .clk(clk), .rst(rst), .segs(segs), .chain(chain),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  gpco_chain_checker u_checker (
    .clk(clk), .rst(rst), .segs(segs), .chain(chain),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .errors(errors), .pending(pending), .chains_done(chains_done),
    .steps_checked(steps_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    chain.ready = 1'b0;
    segs.valid = 1'b0;
    segs.first_x = '0;
    segs.first_y = '0;
    segs.end_x = '0;
    segs.end_y = '0;
    segs.reversible = 1'b0;
    segs.seg_role = '0;
    segs.final_item = 1'b0;
  end

  always @(posedge clk) begin
    chain.ready <= steady ? 1'b1 : ($urandom_range(99) >= 17);
  end

  task automatic write_all(logic [31:0] sx, logic [31:0] sy, logic sff, logic fr,
                           logic [3:0] rf, logic ko);
    logic [31:0] vals [6];
    vals = '{sx, sy, 32'(sff), 32'(fr), 32'(rf), 32'(ko)};
    for (int i = 0; i < 6; i++) begin
      wr_en <= 1'b1;
      wr_index <= 3'(i);
      wr_data <= vals[i];
      @(posedge clk);
    end
    wr_en <= 1'b0;
  endtask

  task automatic send_seg(seg_t s, logic last);
    while (!steady && $urandom_range(99) < 17) begin
      segs.valid <= 1'b0;
      @(posedge clk);
    end
    segs.valid <= 1'b1;
    segs.first_x <= s.fx;
    segs.first_y <= s.fy;
    segs.end_x <= s.ex;
    segs.end_y <= s.ey;
    segs.reversible <= s.rev;
    segs.seg_role <= s.role;
    segs.final_item <= last;
    @(posedge clk);
    while (!segs.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    segs.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_coord(bit wide);
    int r;
    r = $urandom_range(99);
    if (r < 3) return CMIN;
    if (r < 6) return CMAX;
    if (wide) return $urandom;
    return $signed($urandom_range(12)) - 6;
  endfunction

  function automatic seg_t seg(int fx, int fy, int ex, int ey, bit rev, int role);
    seg_t s;
    s.fx = fx;
    s.fy = fy;
    s.ex = ex;
    s.ey = ey;
    s.rev = rev;
    s.role = 4'(role);
    return s;
  endfunction

  initial begin
    seg_t dir [5];
    seg_t s;
    int n, r;
    bit wide;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dir[0] = seg(100, 100, 0, 0, 1, 1);
    dir[1] = seg(CMIN, CMIN, CMAX, CMAX, 0, 15);
    dir[2] = seg(CMAX, CMIN, CMIN, CMAX, 1, 2);
    dir[3] = seg(5, 5, 5, 5, 1, 1);
    dir[4] = seg(5, 5, 6, 6, 0, 1);

    write_all(0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 5; i++) send_seg(dir[i], i == 4);
    wait_drained();
    write_all(0, 0, 1, 1, 1, 0);
    for (int i = 0; i < 5; i++) send_seg(dir[i], i == 4);
    wait_drained();
    write_all(0, 0, 0, 0, 0, 1);
    for (int i = 0; i < 3; i++) send_seg(dir[i], i == 2);
    wait_drained();
    write_all(0, 0, 0, 0, 9, 0);
    send_seg(dir[0], 0);
    send_seg(dir[3], 1);
    wait_drained();
    write_all(CMAX, CMIN, 0, 0, 0, 0);
    send_seg(dir[2], 1);
    wait_drained();

    for (int set_no = 0; items_sent < 310; set_no++) begin
      steady = (set_no >= 20 && set_no < 28);
      if (set_no % 3 == 0) begin
        write_all(pick_coord($urandom_range(1)), pick_coord($urandom_range(1)),
                  $urandom_range(1), $urandom_range(1),
                  $urandom_range(1) ? 4'd0 : 4'($urandom_range(1, 15)),
                  $urandom_range(99) < 20);
      end
      r = $urandom_range(99);
      if (r < 3 && big_sets < 2) begin
        n = 66;
        big_sets++;
      end else if (r < 10) begin
        n = $urandom_range(10, 20);
      end else begin
        n = $urandom_range(1, 6);
      end
      wide = ($urandom_range(99) < 30);
      for (int i = 0; i < n; i++) begin
        s.fx = pick_coord(wide);
        s.fy = pick_coord(wide);
        s.ex = pick_coord(wide);
        s.ey = pick_coord(wide);
        s.rev = $urandom_range(1);
        s.role = ($urandom_range(99) < 5) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 3));
        send_seg(s, i == n - 1);
      end
      wait_drained();
    end
    steady = 1'b0;

    $display("Sent %0d segments in %0d sets; %0d chain results were checked.",
             items_sent, chains_done, steps_checked);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("tb: errors");
    $finish;
  end
endmodule

[filelist.f]
rtl/gpco_pkg.sv
rtl/gpco_seg_if.sv
rtl/gpco_chain_if.sv
rtl/gpco_ram.sv
rtl/gpco_dist.sv
rtl/greedy_path_chain_order.sv
test/gpco_chain_checker.sv
test/tb.sv
